// ===== src/tsht_pkg.sv =====
// tsht_pkg: shared types and constants of the transaction slot horizon tracker
// used by the top level, front and back (not by tsht_fifo); depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package tsht_pkg;

  localparam int OP_W     = 3;
  localparam int SLOT_W   = 4;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int CFG_W    = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic [OP_W-1:0] OP_REGISTER   = 3'd0;
  localparam logic [OP_W-1:0] OP_UNREGISTER = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_ID     = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR_ID   = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_HZN    = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_SLOT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE  = 2'd2;

  typedef enum logic [2:0] {
    KIND_REG,
    KIND_UNREG,
    KIND_SET_ID,
    KIND_CLR_ID,
    KIND_SET_HZN,
    KIND_REJECT
  } req_kind_e;

  typedef struct packed {
    req_kind_e          kind;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted_slot;
    logic [COUNT_W-1:0]  active_count;
    logic [VALUE_W-1:0]  gc_horizon;
  } rsp_t;

endpackage

`default_nettype wire

// ===== src/txn_slot_horizon_tracker.sv =====
// txn_slot_horizon_tracker: top level, front classifier, request queue, slot
// table back end and result queue; depends on tsht_pkg, tsht_fifo, tsht_front,
// tsht_back
//
//   channel   handshake                 payload
//   request   push / full               op_i, slot_i, value_i
//   result    empty / pop               status_o, granted_slot_o, active_count_o,
//                                       gc_horizon_o
//   config    cfg_valid_i / cfg_ready_o cfg_data_i (slot count register)
//
// a transaction passes exec, a free slot search for a register, a scan of all
// SLOT_COUNT slots, drain and done; the horizon scan reads one slot of the
// id and horizon memories per cycle
// two-entry queues sit between the front, the back and the result port,
// so requests are taken while a result waits for pop
// reset clears the slot valid bits, counters and latest id; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module txn_slot_horizon_tracker
  import tsht_pkg::*;
#(
  parameter int SLOT_COUNT = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CFG_W-1:0]    cfg_data_i,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [OP_W-1:0]     op_i,
  input  wire logic [SLOT_W-1:0]   slot_i,
  input  wire logic [VALUE_W-1:0]  value_i,
  output logic                     empty,
  input  wire logic                pop,
  output logic [STATUS_W-1:0]      status_o,
  output logic [SLOT_W-1:0]        granted_slot_o,
  output logic [COUNT_W-1:0]       active_count_o,
  output logic [VALUE_W-1:0]       gc_horizon_o
);

  localparam int CW = $clog2(SLOT_COUNT + 1);

  req_t                  fr_req, bk_req;
  logic                  fr_push, rq_full, rq_empty, bk_pop;
  logic [$bits(req_t)-1:0] rq_out;
  logic [CW-1:0]         limit;
  rsp_t                  bk_rsp, out_rsp;
  logic                  bk_push, oq_full;
  logic [$bits(rsp_t)-1:0] oq_out;

  tsht_front #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .op_i       (op_i),
    .slot_i     (slot_i),
    .value_i    (value_i),
    .req_push_o (fr_push),
    .req_o      (fr_req),
    .req_full_i (rq_full),
    .limit_o    (limit)
  );

  tsht_fifo #(
    .WIDTH($bits(req_t)),
    .DEPTH(2)
  ) u_req_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fr_push),
    .data_i (fr_req),
    .full_o (rq_full),
    .pop_i  (bk_pop),
    .data_o (rq_out),
    .empty_o(rq_empty)
  );

  assign bk_req = req_t'(rq_out);

  tsht_back #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .limit_i    (limit),
    .req_i      (bk_req),
    .req_empty_i(rq_empty),
    .req_pop_o  (bk_pop),
    .rsp_o      (bk_rsp),
    .rsp_push_o (bk_push),
    .rsp_full_i (oq_full)
  );

  tsht_fifo #(
    .WIDTH($bits(rsp_t)),
    .DEPTH(2)
  ) u_rsp_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (bk_push),
    .data_i (bk_rsp),
    .full_o (oq_full),
    .pop_i  (pop),
    .data_o (oq_out),
    .empty_o(empty)
  );

  assign out_rsp        = rsp_t'(oq_out);
  assign status_o       = out_rsp.status;
  assign granted_slot_o = out_rsp.granted_slot;
  assign active_count_o = out_rsp.active_count;
  assign gc_horizon_o   = out_rsp.gc_horizon;

endmodule

`default_nettype wire

// ===== src/tsht_fifo.sv =====
// tsht_fifo: small register queue with push/full and pop/empty sides
// standalone, no package dependency
`timescale 1ns / 1ps
`default_nettype none

module tsht_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == NW'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/tsht_front.sv =====
// tsht_front: slot count register and request classification
// depends on tsht_pkg; feeds the request queue
`timescale 1ns / 1ps
`default_nettype none

module tsht_front
  import tsht_pkg::*;
#(
  parameter int SLOT_COUNT = 16,
  localparam int CW = $clog2(SLOT_COUNT + 1)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CFG_W-1:0]   cfg_data_i,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [OP_W-1:0]    op_i,
  input  wire logic [SLOT_W-1:0]  slot_i,
  input  wire logic [VALUE_W-1:0] value_i,
  output logic                    req_push_o,
  output req_t                    req_o,
  input  wire logic               req_full_i,
  output logic [CW-1:0]           limit_o
);

  localparam int LW = (CW > CFG_W) ? CW : CFG_W;

  logic [CFG_W-1:0] cfg_q;
  logic [LW-1:0]    use_w, cap_w, lim_w;
  logic             in_range;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_data_i;
    end
  end

  // effective count is the smaller of the register and the table size
  assign use_w   = LW'(cfg_q);
  assign cap_w   = LW'(SLOT_COUNT);
  assign lim_w   = (use_w < cap_w) ? use_w : cap_w;
  assign limit_o = CW'(lim_w);
  assign in_range = (LW'(slot_i) < lim_w);

  always_comb begin
    req_o.slot  = slot_i;
    req_o.value = value_i;
    case (op_i)
      OP_REGISTER:   req_o.kind = KIND_REG;
      OP_UNREGISTER: req_o.kind = in_range ? KIND_UNREG : KIND_REJECT;
      OP_SET_ID:     req_o.kind = in_range ? KIND_SET_ID : KIND_REJECT;
      OP_CLEAR_ID:   req_o.kind = in_range ? KIND_CLR_ID : KIND_REJECT;
      OP_SET_HZN:    req_o.kind = in_range ? KIND_SET_HZN : KIND_REJECT;
      default:       req_o.kind = KIND_REJECT;
    endcase
  end

  assign full       = req_full_i;
  assign req_push_o = push && !req_full_i;

endmodule

`default_nettype wire

// ===== src/tsht_back.sv =====
// tsht_back: slot table, request execution and horizon scan
// depends on tsht_pkg; pops the request queue and pushes the result queue
`timescale 1ns / 1ps
`default_nettype none

module tsht_back
  import tsht_pkg::*;
#(
  parameter int SLOT_COUNT = 16,
  localparam int CW = $clog2(SLOT_COUNT + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [CW-1:0] limit_i,
  input  wire req_t          req_i,
  input  wire logic          req_empty_i,
  output logic               req_pop_o,
  output rsp_t               rsp_o,
  output logic               rsp_push_o,
  input  wire logic          rsp_full_i
);

  localparam int SW = $clog2(SLOT_COUNT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_e;

  state_e                state_q;
  req_t                  req_q;
  logic [SLOT_COUNT-1:0] act_q;
  logic [CW-1:0]         live_q;
  logic [VALUE_W-1:0]    done_q;
  logic [CW-1:0]         idx_q;
  logic [STATUS_W-1:0]   status_q;
  logic [SLOT_W-1:0]     grant_q;
  logic                  p1_q, p2_q;
  logic                  rd_act_q;
  logic [VALUE_W-1:0]    rd_txn_q, rd_snap_q;
  logic [VALUE_W-1:0]    cand_q, best_q;
  logic                  cand_ok_q, found_q;

  logic [VALUE_W-1:0] txn_mem  [SLOT_COUNT];
  logic [VALUE_W-1:0] snap_mem [SLOT_COUNT];

  logic [SW-1:0]      slot_w, idx_w, rd_addr;
  logic               we_txn, we_snap;
  logic [SW-1:0]      wr_addr;
  logic [VALUE_W-1:0] wd_txn, wd_snap;
  logic               txn_nz, snap_nz;

  assign slot_w = SW'(req_q.slot);
  assign idx_w  = idx_q[SW-1:0];

  assign req_pop_o  = (state_q == S_IDLE) && !req_empty_i;
  assign rsp_push_o = (state_q == S_DONE) && !rsp_full_i;

  assign rsp_o.status       = status_q;
  assign rsp_o.granted_slot = grant_q;
  assign rsp_o.active_count = COUNT_W'(live_q);
  assign rsp_o.gc_horizon   = found_q ? best_q : done_q;

  // old id of the addressed slot is fetched while the request is popped
  assign rd_addr = (state_q == S_IDLE) ? SW'(req_i.slot) : idx_w;

  always_comb begin
    we_txn  = 1'b0;
    we_snap = 1'b0;
    wr_addr = slot_w;
    wd_txn  = '0;
    wd_snap = '0;
    if (state_q == S_EXEC && act_q[slot_w]) begin
      case (req_q.kind)
        KIND_UNREG: begin
          we_txn  = 1'b1;
          we_snap = 1'b1;
        end
        KIND_SET_ID: begin
          we_txn = 1'b1;
          wd_txn = req_q.value;
        end
        KIND_CLR_ID: begin
          we_txn = 1'b1;
        end
        KIND_SET_HZN: begin
          we_snap = 1'b1;
          wd_snap = req_q.value;
        end
        default: begin
          we_txn  = 1'b0;
          we_snap = 1'b0;
        end
      endcase
    end else if (state_q == S_SEARCH && idx_q < limit_i && !act_q[idx_w]) begin
      we_txn  = 1'b1;
      we_snap = 1'b1;
      wr_addr = idx_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_txn) begin
      txn_mem[wr_addr] <= wd_txn;
    end
    if (we_snap) begin
      snap_mem[wr_addr] <= wd_snap;
    end
    rd_txn_q  <= txn_mem[rd_addr];
    rd_snap_q <= snap_mem[rd_addr];
  end

  assign txn_nz  = rd_act_q && (rd_txn_q != '0);
  assign snap_nz = rd_act_q && (rd_snap_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      req_q     <= '0;
      act_q     <= '0;
      live_q    <= '0;
      done_q    <= '0;
      idx_q     <= '0;
      status_q  <= STATUS_OK;
      grant_q   <= '0;
      p1_q      <= 1'b0;
      p2_q      <= 1'b0;
      rd_act_q  <= 1'b0;
      cand_q    <= '0;
      cand_ok_q <= 1'b0;
      best_q    <= '0;
      found_q   <= 1'b0;
    end else begin
      rd_act_q <= act_q[rd_addr];
      p1_q     <= (state_q == S_SCAN);
      p2_q     <= p1_q;

      // pair minimum of one slot's id and horizon
      if (p1_q) begin
        cand_ok_q <= txn_nz || snap_nz;
        if (txn_nz && (!snap_nz || rd_txn_q < rd_snap_q)) begin
          cand_q <= rd_txn_q;
        end else begin
          cand_q <= rd_snap_q;
        end
      end

      // running minimum over slots
      if (p2_q && cand_ok_q && (!found_q || cand_q < best_q)) begin
        best_q  <= cand_q;
        found_q <= 1'b1;
      end

      case (state_q)
        S_IDLE: begin
          if (!req_empty_i) begin
            req_q    <= req_i;
            status_q <= STATUS_OK;
            grant_q  <= '0;
            found_q  <= 1'b0;
            idx_q    <= '0;
            state_q  <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (req_q.kind == KIND_REJECT) begin
            status_q <= STATUS_BAD_SLOT;
            state_q  <= S_SCAN;
          end else if (req_q.kind == KIND_REG) begin
            state_q <= S_SEARCH;
          end else if (!act_q[slot_w]) begin
            status_q <= STATUS_BAD_SLOT;
            state_q  <= S_SCAN;
          end else begin
            state_q <= S_SCAN;
            case (req_q.kind)
              KIND_UNREG: begin
                act_q[slot_w] <= 1'b0;
                live_q        <= live_q - 1'b1;
              end
              KIND_SET_ID: begin
                if (req_q.value > done_q) begin
                  done_q <= req_q.value;
                end
              end
              KIND_CLR_ID: begin
                if (rd_txn_q > done_q) begin
                  done_q <= rd_txn_q;
                end
              end
              default: begin
                done_q <= done_q;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (idx_q >= limit_i) begin
            status_q <= STATUS_NO_FREE;
            idx_q    <= '0;
            state_q  <= S_SCAN;
          end else if (!act_q[idx_w]) begin
            act_q[idx_w] <= 1'b1;
            live_q       <= live_q + 1'b1;
            grant_q      <= SLOT_W'(idx_q);
            idx_q        <= '0;
            state_q      <= S_SCAN;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_SCAN: begin
          if (idx_q == CW'(SLOT_COUNT - 1)) begin
            state_q <= S_DRAIN;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!p1_q && !p2_q) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_full_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
